/* rtl/core/mifsr_pkg.sv */
// mifsr_pkg: shared types and constants for the motor start-up ramp sequencer
// no dependencies; used by mifsr_cfg, motor_if_startup_ramp_top and mifsr_chk by scoped names

package mifsr_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ALIGN_DURATION  = 3'd0;
    localparam logic [2:0] REG_ALIGN_CURRENT   = 3'd1;
    localparam logic [2:0] REG_CURRENT_SLOPE   = 3'd2;
    localparam logic [2:0] REG_START_FREQUENCY = 3'd3;
    localparam logic [2:0] REG_FREQUENCY_SLOPE = 3'd4;
    localparam logic [2:0] REG_END_FREQUENCY   = 3'd5;

    // configuration reset values
    localparam logic [31:0] RST_ALIGN_DURATION  = 32'd1677722;
    localparam logic [23:0] RST_ALIGN_CURRENT   = 24'd65536;
    localparam logic [31:0] RST_CURRENT_SLOPE   = 32'd327680;
    localparam logic [31:0] RST_START_FREQUENCY = 32'd131072;
    localparam logic [31:0] RST_FREQUENCY_SLOPE = 32'd655360;
    localparam logic [31:0] RST_END_FREQUENCY   = 32'd2621440;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CFG   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd2;

    // request codes
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic [31:0] align_duration;
        logic [23:0] align_current;
        logic [31:0] current_slope;
        logic [31:0] start_frequency;
        logic [31:0] frequency_slope;
        logic [31:0] end_frequency;
        logic        ok;
    } t_cfg;

endpackage

/* rtl/core/mifsr_cfg.sv */
// mifsr_cfg: configuration register file and validity check
// depends on mifsr_pkg

module mifsr_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output mifsr_pkg::t_cfg    o_cfg
);

    logic [31:0] r_align_duration;
    logic [23:0] r_align_current;
    logic [31:0] r_current_slope;
    logic [31:0] r_start_frequency;
    logic [31:0] r_frequency_slope;
    logic [31:0] r_end_frequency;

    // register writes, out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_duration  <= mifsr_pkg::RST_ALIGN_DURATION;
            r_align_current   <= mifsr_pkg::RST_ALIGN_CURRENT;
            r_current_slope   <= mifsr_pkg::RST_CURRENT_SLOPE;
            r_start_frequency <= mifsr_pkg::RST_START_FREQUENCY;
            r_frequency_slope <= mifsr_pkg::RST_FREQUENCY_SLOPE;
            r_end_frequency   <= mifsr_pkg::RST_END_FREQUENCY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mifsr_pkg::REG_ALIGN_DURATION:  r_align_duration  <= i_cfg_data;
                mifsr_pkg::REG_ALIGN_CURRENT:   r_align_current   <= i_cfg_data[23:0];
                mifsr_pkg::REG_CURRENT_SLOPE:   r_current_slope   <= i_cfg_data;
                mifsr_pkg::REG_START_FREQUENCY: r_start_frequency <= i_cfg_data;
                mifsr_pkg::REG_FREQUENCY_SLOPE: r_frequency_slope <= i_cfg_data;
                mifsr_pkg::REG_END_FREQUENCY:   r_end_frequency   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // export with validity flag
    always_comb begin
        o_cfg.align_duration  = r_align_duration;
        o_cfg.align_current   = r_align_current;
        o_cfg.current_slope   = r_current_slope;
        o_cfg.start_frequency = r_start_frequency;
        o_cfg.frequency_slope = r_frequency_slope;
        o_cfg.end_frequency   = r_end_frequency;
        o_cfg.ok = (r_align_current != 24'd0) && (r_current_slope != 32'd0) &&
                   (r_frequency_slope != 32'd0) && (r_end_frequency > r_start_frequency);
    end

endmodule

/* rtl/core/mifsr_mul.sv */
// mifsr_mul: shared 32x16 unsigned multiplier with registered product
// no dependencies

module mifsr_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [15:0] i_b,
    output logic [47:0] o_p
);

    logic [47:0] r_p;

    // one product per cycle, result in the following cycle
    always_ff @(posedge i_clk) begin
        r_p <= {16'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

/* rtl/core/motor_if_startup_ramp_top.sv */
// motor_if_startup_ramp_top: open-loop current/frequency start-up sequencer
// depends on mifsr_pkg, mifsr_cfg, mifsr_mul

// A restart beat, or one rejected for bad configuration or zero step time,
// goes from acceptance straight to the done state. A tick beat updates the
// elapsed time; then, while ramping, the current, frequency and phase steps
// each go through the one shared 32x16 multiplier in turn, one multiply and
// one accumulate state each, under a small sequencer; aligning: phase only.
// The input is not ready while a beat is in work; the finished result sits in
// an output register, and the next beat is accepted as soon as the sequencer
// has handed its result over, even if that result has not been taken yet.

module motor_if_startup_ramp_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_step_time,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [23:0] o_current_d,
    output logic [31:0] o_electrical_angle,
    output logic [31:0] o_frequency,
    output logic        o_aligning,
    output logic        o_ramp_done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ELAP  = 4'd1;
    localparam logic [3:0] S_ALIGN = 4'd2;
    localparam logic [3:0] S_CMUL  = 4'd3;
    localparam logic [3:0] S_CADD  = 4'd4;
    localparam logic [3:0] S_FMUL  = 4'd5;
    localparam logic [3:0] S_FADD  = 4'd6;
    localparam logic [3:0] S_PMUL  = 4'd7;
    localparam logic [3:0] S_PADD  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    mifsr_pkg::t_cfg cfg;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_dt, n_dt;
    logic [1:0]  r_status, n_status;

    logic [31:0] r_elapsed, n_elapsed;
    logic        r_align, n_align;
    logic [47:0] r_cur, n_cur;
    logic [55:0] r_frq, n_frq;
    logic [39:0] r_ph, n_ph;
    logic        r_rtc, n_rtc;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status;
    logic [23:0] r_out_cur;
    logic [31:0] r_out_angle;
    logic [31:0] r_out_frq;
    logic        r_out_align;
    logic        r_out_rtc;

    logic [31:0] mul_a;
    logic [47:0] prod;
    logic [47:0] full_i;
    logic [47:0] quarter_i;
    logic [55:0] end_f;
    logic [55:0] start_f;
    logic [32:0] elap_sum;
    logic [48:0] c_sum;
    logic [56:0] f_sum;
    logic        in_beat;
    logic        out_beat;
    logic        out_free;

    mifsr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_CMUL:  mul_a = cfg.current_slope;
            S_FMUL:  mul_a = cfg.frequency_slope;
            S_PMUL:  mul_a = r_frq[55:24];
            default: mul_a = cfg.current_slope;
        endcase
    end

    mifsr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_dt),
        .o_p   (prod)
    );

    // fixed-point limits
    assign full_i    = {cfg.align_current, 24'd0};
    assign quarter_i = {2'd0, cfg.align_current, 22'd0};
    assign end_f     = {cfg.end_frequency, 24'd0};
    assign start_f   = {cfg.start_frequency, 24'd0};
    assign elap_sum  = {1'b0, r_elapsed} + {17'd0, r_dt};
    assign c_sum     = {1'b0, r_cur} + {1'b0, prod};
    assign f_sum     = {1'b0, r_frq} + {9'd0, prod};

    assign in_beat  = i_valid && o_ready;
    assign out_beat = r_out_valid && i_ready;
    assign out_free = !r_out_valid || i_ready;

    // sequencer and state update
    always_comb begin
        n_state     = r_state;
        n_dt        = r_dt;
        n_status    = r_status;
        n_elapsed   = r_elapsed;
        n_align     = r_align;
        n_cur       = r_cur;
        n_frq       = r_frq;
        n_ph        = r_ph;
        n_rtc       = r_rtc;
        n_out_valid = out_beat ? 1'b0 : r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_dt     = i_step_time;
                    n_status = mifsr_pkg::STATUS_OK;
                    n_state  = S_DONE;
                    if (!cfg.ok) begin
                        n_status = mifsr_pkg::STATUS_BAD_CFG;
                    end else if (i_req_type == mifsr_pkg::REQ_RESTART) begin
                        n_elapsed = 32'd0;
                        n_align   = (cfg.align_duration != 32'd0);
                        n_cur     = n_align ? full_i : quarter_i;
                        n_frq     = n_align ? 56'd0 : start_f;
                        n_ph      = 40'd0;
                        n_rtc     = 1'b0;
                    end else if (i_step_time == 16'd0) begin
                        n_status = mifsr_pkg::STATUS_ZERO_STEP;
                    end else begin
                        n_state = S_ELAP;
                    end
                end
            end
            S_ELAP: begin
                n_elapsed = elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0];
                n_state   = r_align ? S_ALIGN : S_CMUL;
            end
            S_ALIGN: begin
                if (r_elapsed >= cfg.align_duration) begin
                    n_align = 1'b0;
                    n_cur   = quarter_i;
                    n_frq   = start_f;
                end else begin
                    n_cur = full_i;
                    n_frq = 56'd0;
                end
                n_state = S_PMUL;
            end
            S_CMUL: begin
                n_state = S_CADD;
            end
            S_CADD: begin
                n_cur   = (c_sum > {1'b0, full_i}) ? full_i : c_sum[47:0];
                n_state = S_FMUL;
            end
            S_FMUL: begin
                n_state = S_FADD;
            end
            S_FADD: begin
                if (f_sum >= {1'b0, end_f}) begin
                    n_frq = end_f;
                    n_rtc = 1'b1;
                end else begin
                    n_frq = f_sum[55:0];
                end
                n_state = S_PMUL;
            end
            S_PMUL: begin
                n_state = S_PADD;
            end
            S_PADD: begin
                n_ph    = r_ph + prod[39:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and run state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_elapsed   <= 32'd0;
            r_align     <= 1'b1;
            r_cur       <= {mifsr_pkg::RST_ALIGN_CURRENT, 24'd0};
            r_frq       <= 56'd0;
            r_ph        <= 40'd0;
            r_rtc       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_elapsed   <= n_elapsed;
            r_align     <= n_align;
            r_cur       <= n_cur;
            r_frq       <= n_frq;
            r_ph        <= n_ph;
            r_rtc       <= n_rtc;
        end
    end

    // beat payload registers
    always_ff @(posedge i_clk) begin
        r_dt     <= n_dt;
        r_status <= n_status;
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_cur    <= r_cur[47:24];
            r_out_angle  <= r_ph[39:8];
            r_out_frq    <= r_frq[55:24];
            r_out_align  <= r_align;
            r_out_rtc    <= r_rtc;
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_current_d        = r_out_cur;
    assign o_electrical_angle = r_out_angle;
    assign o_frequency        = r_out_frq;
    assign o_aligning         = r_out_align;
    assign o_ramp_done        = r_out_rtc;

endmodule

/* rtl/core/mifsr_chk.sv */
// mifsr_chk: port-level checker for the start-up ramp sequencer
// depends on mifsr_pkg and motor_if_startup_ramp_top; bound to it at the end of this file

module mifsr_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_status,
    input  logic [31:0] o_frequency,
    input  logic        o_aligning,
    input  logic        o_ramp_done
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result beat dropped while stalled");

    // the block takes one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while previous one in work");

    // status stays within its codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == mifsr_pkg::STATUS_OK) ||
                     (o_status == mifsr_pkg::STATUS_BAD_CFG) ||
                     (o_status == mifsr_pkg::STATUS_ZERO_STEP)))
        else $error("undefined status code");

    // frequency is held at zero during alignment
    a_align_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_aligning) |-> (o_frequency == 32'd0))
        else $error("nonzero frequency while aligning");

    // ramp completion never coexists with alignment
    a_close_not_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ramp_done) |-> !o_aligning)
        else $error("ramp done while aligning");

endmodule

bind motor_if_startup_ramp_top mifsr_chk u_mifsr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_frequency (o_frequency),
    .o_aligning  (o_aligning),
    .o_ramp_done (o_ramp_done)
);
